// File: design/i2cme_pkg.sv
package i2cme_pkg;

    // Bus command codes carried in the opcode field.
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STOP  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // Phase counter covers the longest command body (a read, 19 phases).
    localparam int PHASE_W = 5;
    localparam logic [PHASE_W-1:0] LAST_SHORT = 5'd2;
    localparam logic [PHASE_W-1:0] LAST_WRITE = 5'd17;
    localparam logic [PHASE_W-1:0] LAST_READ  = 5'd18;
    localparam logic [PHASE_W-1:0] READ_HIGH  = 5'd17;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] write_data;
        logic       final_read;
        logic [8:0] line_samples;
    } cmd_item_t;

    typedef struct packed {
        logic       clock_level;
        logic       data_level;
        logic [7:0] read_byte;
        logic       nacked;
        logic       last_phase;
    } result_item_t;

    typedef enum logic [1:0] {
        CTRL_IDLE,
        CTRL_LEAD,
        CTRL_BODY
    } ctrl_state_t;

    typedef struct packed {
        logic               load;
        logic               emit_lead;
        logic               emit_body;
        logic [PHASE_W-1:0] phase;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clock_high;
        logic body_last;
        logic out_free;
    } dp_status_t;

endpackage

// File: design/i2cme_ctrl.sv
module i2cme_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  i2cme_pkg::dp_status_t  status,
    output i2cme_pkg::ctrl_cmd_t   cmd
);

    i2cme_pkg::ctrl_state_t            state_reg;
    i2cme_pkg::ctrl_state_t            state_next;
    logic [i2cme_pkg::PHASE_W-1:0]     phase_reg;
    logic [i2cme_pkg::PHASE_W-1:0]     phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= i2cme_pkg::CTRL_IDLE;
            phase_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        in_ready      = 1'b0;
        cmd.load      = 1'b0;
        cmd.emit_lead = 1'b0;
        cmd.emit_body = 1'b0;
        cmd.phase     = phase_reg;
        unique case (state_reg)
            i2cme_pkg::CTRL_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    phase_next = '0;
                    // A command that finds SCL high first pulls it low.
                    state_next = status.clock_high ? i2cme_pkg::CTRL_LEAD
                                                   : i2cme_pkg::CTRL_BODY;
                end
            end
            i2cme_pkg::CTRL_LEAD:
            begin
                if (status.out_free)
                begin
                    cmd.emit_lead = 1'b1;
                    state_next    = i2cme_pkg::CTRL_BODY;
                end
            end
            i2cme_pkg::CTRL_BODY:
            begin
                if (status.out_free)
                begin
                    cmd.emit_body = 1'b1;
                    if (status.body_last)
                    begin
                        state_next = i2cme_pkg::CTRL_IDLE;
                        phase_next = '0;
                    end
                    else
                    begin
                        phase_next = phase_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = i2cme_pkg::CTRL_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= i2cme_pkg::LAST_READ)
        else $error("phase counter ran past the longest command");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == i2cme_pkg::CTRL_IDLE && in_valid) |=>
        (state_reg != i2cme_pkg::CTRL_IDLE))
        else $error("accepted command did not start");
`endif

endmodule

// File: design/i2cme_dp.sv
module i2cme_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  i2cme_pkg::cmd_item_t      in_data,
    input  i2cme_pkg::ctrl_cmd_t      cmd,
    output i2cme_pkg::dp_status_t     status,
    output logic                      out_valid,
    input  logic                      out_ready,
    output i2cme_pkg::result_item_t   out_data
);

    i2cme_pkg::cmd_item_t      item_reg;
    i2cme_pkg::result_item_t   out_reg;
    i2cme_pkg::result_item_t   phase_res;
    logic                      out_valid_reg;
    logic                      clock_out_reg;
    logic                      data_out_reg;
    logic                      body_scl;
    logic                      body_sda;
    logic                      body_last;

    // Bus levels of one phase of the command body.
    always_comb
    begin
        body_scl  = cmd.phase[0];
        body_sda  = 1'b1;
        body_last = 1'b0;
        unique case (item_reg.opcode)
            i2cme_pkg::OP_START:
            begin
                body_scl  = (cmd.phase != '0);
                body_sda  = (cmd.phase != i2cme_pkg::LAST_SHORT);
                body_last = (cmd.phase == i2cme_pkg::LAST_SHORT);
            end
            i2cme_pkg::OP_STOP:
            begin
                body_scl  = (cmd.phase != '0);
                body_sda  = (cmd.phase == i2cme_pkg::LAST_SHORT);
                body_last = (cmd.phase == i2cme_pkg::LAST_SHORT);
            end
            i2cme_pkg::OP_WRITE:
            begin
                // Data bits go out MSB first; the ack clock releases SDA.
                body_sda  = cmd.phase[4] ? 1'b1 : item_reg.write_data[~cmd.phase[3:1]];
                body_last = (cmd.phase == i2cme_pkg::LAST_WRITE);
            end
            i2cme_pkg::OP_READ:
            begin
                if (cmd.phase[4])
                begin
                    body_scl = (cmd.phase == i2cme_pkg::READ_HIGH);
                    body_sda = item_reg.final_read;
                end
                body_last = (cmd.phase == i2cme_pkg::LAST_READ);
            end
            default:
            begin
                body_last = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        phase_res             = '0;
        if (cmd.emit_lead)
        begin
            phase_res.data_level = data_out_reg;
        end
        else
        begin
            phase_res.clock_level = body_scl;
            phase_res.data_level  = body_sda;
            phase_res.last_phase  = body_last;
            if (body_last && item_reg.opcode == i2cme_pkg::OP_READ)
            begin
                phase_res.read_byte = item_reg.line_samples[8:1];
            end
            if (body_last && item_reg.opcode == i2cme_pkg::OP_WRITE)
            begin
                phase_res.nacked = item_reg.line_samples[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_data;
        end
        if (cmd.emit_lead || cmd.emit_body)
        begin
            out_reg <= phase_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            clock_out_reg <= 1'b1;
            data_out_reg  <= 1'b1;
        end
        else
        begin
            if (cmd.emit_lead || cmd.emit_body)
            begin
                out_valid_reg <= 1'b1;
                clock_out_reg <= phase_res.clock_level;
                data_out_reg  <= phase_res.data_level;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.clock_high = clock_out_reg;
    assign status.body_last  = body_last;
    assign status.out_free   = !out_valid_reg || out_ready;
    assign out_valid         = out_valid_reg;
    assign out_data          = out_reg;

`ifndef SYNTHESIS
    a_levels_track: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.clock_level == clock_out_reg &&
                           out_reg.data_level == data_out_reg))
        else $error("bus level state differs from the last phase shown");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_lead || cmd.emit_body) |-> (!out_valid_reg || out_ready))
        else $error("phase written over an untaken beat");
`endif

endmodule

// File: design/i2c_master_byte_engine_core.sv
// Channel | Dir | Handshake              | Payload
// --------+-----+------------------------+--------------------------------
// in      | in  | in_valid / in_ready    | in_data  (i2cme_pkg::cmd_item_t)
// out     | out | out_valid / out_ready  | out_data (i2cme_pkg::result_item_t)
//
// Each command beat yields 3 to 20 phase beats, one per clock when the output
// side keeps taking them: 3 for start/stop, 18 for a write, 19 for a read,
// plus one leading SCL-low phase when SCL is high as the command begins.
// The phase sequencer handles one command at a time; the next command is
// taken as soon as its last phase sits in the output register.
// Reset leaves SCL and SDA released high and the output register empty.
// A stalled output holds the sequencer on the current phase.
module i2c_master_byte_engine_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  i2cme_pkg::cmd_item_t      in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output i2cme_pkg::result_item_t   out_data
);

    // Command and status between the phase sequencer and the datapath.
    i2cme_pkg::ctrl_cmd_t    cmd;
    i2cme_pkg::dp_status_t   status;

    // The controller walks the leading clock fall and the body phases of
    // each command, advancing only when the output register can take a beat.
    i2cme_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the command, the current bus levels, and the
    // output register; it decodes SCL/SDA for the phase the controller names.
    i2cme_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// File: verif/i2cme_phase_checker.sv
module i2cme_phase_checker
    import i2cme_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_ready,
    input  cmd_item_t    in_data,
    input  logic         out_valid,
    input  logic         out_ready,
    input  result_item_t out_data,
    output int           mismatches,
    output int           outstanding
);

    // Bus phases still owed by the engine, oldest first.
    result_item_t phase_q[$];

    // Line levels after the last predicted phase.
    logic scl_level;
    logic sda_level;

    task automatic add_phase(input logic scl, input logic sda);
        result_item_t p;
        p             = '0;
        p.clock_level = scl;
        p.data_level  = sda;
        scl_level     = scl;
        sda_level     = sda;
        phase_q.push_back(p);
    endtask

    task automatic expand_command(input cmd_item_t c);
        result_item_t tail;
        logic [7:0]   shifter;
        int           i;
        // SCL must be low before any data change, so a high clock is dropped first.
        if (scl_level)
            add_phase(1'b0, sda_level);
        case (c.opcode)
            OP_START:
            begin
                add_phase(1'b0, 1'b1);
                add_phase(1'b1, 1'b1);
                add_phase(1'b1, 1'b0);
            end
            OP_STOP:
            begin
                add_phase(1'b0, 1'b0);
                add_phase(1'b1, 1'b0);
                add_phase(1'b1, 1'b1);
            end
            OP_WRITE:
            begin
                shifter = c.write_data;
                for (i = 0; i < 8; i++)
                begin
                    add_phase(1'b0, shifter[7]);
                    add_phase(1'b1, shifter[7]);
                    shifter = shifter << 1;
                end
                add_phase(1'b0, 1'b1);
                add_phase(1'b1, 1'b1);
            end
            default:
            begin
                for (i = 0; i < 8; i++)
                begin
                    add_phase(1'b0, 1'b1);
                    add_phase(1'b1, 1'b1);
                end
                add_phase(1'b0, c.final_read);
                add_phase(1'b1, c.final_read);
                add_phase(1'b0, c.final_read);
            end
        endcase
        tail = phase_q.pop_back();
        if (c.opcode == OP_WRITE)
            tail.nacked = c.line_samples[0];
        if (c.opcode == OP_READ)
            tail.read_byte = c.line_samples[8:1];
        tail.last_phase = 1'b1;
        phase_q.push_back(tail);
    endtask

    task automatic report(input string what, input result_item_t exp_p, input result_item_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $write("%s: expected scl=%0b sda=%0b byte=%02h nack=%0b last=%0b, ",
                   what, exp_p.clock_level, exp_p.data_level, exp_p.read_byte,
                   exp_p.nacked, exp_p.last_phase);
            $display("got scl=%0b sda=%0b byte=%02h nack=%0b last=%0b",
                     got.clock_level, got.data_level, got.read_byte,
                     got.nacked, got.last_phase);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_item_t exp_p;
        if (!rst_n)
        begin
            phase_q.delete();
            scl_level   = 1'b1;
            sda_level   = 1'b1;
            mismatches  = 0;
            outstanding <= 0;
        end
        else
        begin
            // A command beat and the last phase of the one before can meet on one edge.
            if (in_valid && in_ready)
                expand_command(in_data);
            if (out_valid && out_ready)
            begin
                if (phase_q.size() == 0)
                    report("unexpected phase beat", '0, out_data);
                else
                begin
                    exp_p = phase_q.pop_front();
                    if (out_data.clock_level !== exp_p.clock_level ||
                        out_data.data_level  !== exp_p.data_level  ||
                        out_data.read_byte   !== exp_p.read_byte   ||
                        out_data.nacked      !== exp_p.nacked      ||
                        out_data.last_phase  !== exp_p.last_phase)
                        report("phase mismatch", exp_p, out_data);
                end
            end
            outstanding <= phase_q.size();
        end
    end

endmodule

// File: verif/i2c_master_byte_engine_core_test.sv
module i2c_master_byte_engine_core_test;

    import i2cme_pkg::*;

    // The slowest correct run: about 230 commands of up to 20 phases, each phase
    // possibly held off by a receiver stall, plus sender gaps. The limit sits
    // several times above that.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TOTAL_ITEMS  = 230;
    localparam int CALM_FROM    = 195;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         in_valid;
    logic         in_ready;
    cmd_item_t    in_data;
    logic         out_valid;
    logic         out_ready;
    result_item_t out_data;

    int mismatches;
    int outstanding;
    int cycles = 0;
    int sent = 0;
    int gap_pct = 0;
    bit calm = 1'b0;

    i2c_master_byte_engine_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // The checker watches both channels, predicts every bus phase and counts failures.
    i2cme_phase_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver side: runs of ready of random length, broken by stalls of random
    // length. Long runs give stretches with no stalls at all. Once the run is in
    // its calm tail the receiver always takes beats.
    initial
    begin
        int run;
        out_ready = 1'b0;
        forever
        begin
            run = $urandom_range(1, 30);
            out_ready <= 1'b1;
            repeat (run) @(posedge clk);
            if (!calm && $urandom_range(0, 3) != 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
        end
    end

    function automatic cmd_item_t make_cmd(input logic [1:0] op, input logic [7:0] wd,
                                           input logic fin, input logic [8:0] samples);
        cmd_item_t c;
        c.opcode       = op;
        c.write_data   = wd;
        c.final_read   = fin;
        c.line_samples = samples;
        return c;
    endfunction

    // Random content for every field; the unused ones still toggle so that every
    // input bit sees both values.
    function automatic cmd_item_t random_cmd(input logic [1:0] op);
        return make_cmd(op, 8'($urandom), 1'($urandom), 9'($urandom));
    endfunction

    // Presents one command beat and holds it until the engine takes it. A gap
    // may follow; without one, valid simply stays high for the next beat.
    task automatic send_command(input cmd_item_t c);
        in_valid <= 1'b1;
        in_data  <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
        if (sent >= CALM_FROM)
            calm = 1'b1;
        if (!calm && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // Holds off the sender until every predicted phase has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // A well-formed transfer: start, address byte, a few data writes or reads
    // (the last read marked final), sometimes a repeated start and a final read, then stop.
    task automatic send_transfer();
        cmd_item_t c;
        int        n;
        int        k;
        c = random_cmd(OP_WRITE);
        send_command(random_cmd(OP_START));
        // Mostly an acknowledged address, sometimes a NACK.
        if ($urandom_range(0, 3) != 0)
            c.line_samples[0] = 1'b0;
        send_command(c);
        n = $urandom_range(1, 4);
        if ($urandom_range(0, 1) == 0)
        begin
            for (k = 0; k < n; k++)
                send_command(random_cmd(OP_WRITE));
        end
        else
        begin
            for (k = 0; k < n; k++)
            begin
                c = random_cmd(OP_READ);
                c.final_read = (k == n - 1);
                send_command(c);
            end
        end
        if ($urandom_range(0, 4) == 0)
        begin
            send_command(random_cmd(OP_START));
            c = random_cmd(OP_READ);
            c.final_read = 1'b1;
            send_command(c);
        end
        send_command(random_cmd(OP_STOP));
    endtask

    initial
    begin
        cmd_item_t directed[$];
        int        pick;
        bit        paused;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Commands start from each entry state of the lines: SCL
        // high with SDA high (after reset, stop), SCL high with SDA low (after
        // start), SCL high after a write, SCL low after a read (all four commands).
        // Field extremes and alternating bit patterns come along the way.
        directed.push_back(make_cmd(OP_STOP,  8'h00, 1'b0, 9'h000));
        directed.push_back(make_cmd(OP_STOP,  8'hFF, 1'b1, 9'h1FF));
        directed.push_back(make_cmd(OP_START, 8'h00, 1'b0, 9'h000));
        directed.push_back(make_cmd(OP_START, 8'hFF, 1'b1, 9'h1FF));
        directed.push_back(make_cmd(OP_WRITE, 8'hFF, 1'b0, 9'h000));
        directed.push_back(make_cmd(OP_WRITE, 8'h00, 1'b1, 9'h1FF));
        directed.push_back(make_cmd(OP_READ,  8'h00, 1'b0, 9'h1FF));
        directed.push_back(make_cmd(OP_READ,  8'hFF, 1'b1, 9'h000));
        directed.push_back(make_cmd(OP_WRITE, 8'hA5, 1'b0, 9'h001));
        directed.push_back(make_cmd(OP_READ,  8'h5A, 1'b0, 9'h155));
        directed.push_back(make_cmd(OP_READ,  8'hA5, 1'b1, 9'h0AA));
        directed.push_back(make_cmd(OP_STOP,  8'h00, 1'b0, 9'h000));
        directed.push_back(make_cmd(OP_READ,  8'hFF, 1'b1, 9'h0FF));
        directed.push_back(make_cmd(OP_START, 8'h00, 1'b0, 9'h000));
        directed.push_back(make_cmd(OP_WRITE, 8'h5A, 1'b0, 9'h1FE));
        directed.push_back(make_cmd(OP_STOP,  8'h00, 1'b0, 9'h000));
        directed.push_back(make_cmd(OP_START, 8'h00, 1'b0, 9'h000));
        directed.push_back(make_cmd(OP_WRITE, 8'h80, 1'b0, 9'h100));
        directed.push_back(make_cmd(OP_WRITE, 8'h01, 1'b1, 9'h0FF));
        directed.push_back(make_cmd(OP_READ,  8'h00, 1'b1, 9'h100));
        directed.push_back(make_cmd(OP_START, 8'h00, 1'b0, 9'h000));
        directed.push_back(make_cmd(OP_STOP,  8'h00, 1'b0, 9'h000));
        gap_pct = 30;
        foreach (directed[i])
            send_command(directed[i]);

        // Let the engine run completely dry once before the random part.
        wait_drained();

        // Random part: mostly well-formed transfers, with stray commands mixed
        // in as noise. The idle density changes per transfer so that some
        // stretches have no sender gaps.
        paused = 1'b0;
        while (sent < TOTAL_ITEMS)
        begin
            pick = $urandom_range(0, 2);
            gap_pct = (pick == 0) ? 0 : (pick == 1) ? 25 : 60;
            if ($urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(1, 4))
                    send_command(random_cmd(2'($urandom)));
            end
            else
                send_transfer();
            if (!paused && sent >= TOTAL_ITEMS / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
        end

        // Wait for the last phases, then a little longer to catch strays.
        wait_drained();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: sim.f
design/i2cme_pkg.sv
design/i2cme_ctrl.sv
design/i2cme_dp.sv
design/i2c_master_byte_engine_core.sv
verif/i2cme_phase_checker.sv
verif/i2c_master_byte_engine_core_test.sv
